[rtl/hpid_pkg.sv]
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared types and codes for the HPACK prefixed integer decoder.
// ----------------------------------------------------------------------------
package hpid_pkg;

    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned SHIFT_W  = 6;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned PBITS_W  = 4;

    localparam logic [PBITS_W-1:0]  PREFIX_BITS_RESET = 4'd7;
    localparam logic [SHIFT_W-1:0]  LAST_SHIFT        = 6'd63;
    localparam logic [SHIFT_W-1:0]  GROUP_BITS        = 6'd7;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    // decoder state carried between bytes
    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [SHIFT_W-1:0] shift;
        logic               busy;
        logic [COUNT_W-1:0] count;
    } t_state;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic                leading_zeros;
        logic [COUNT_W-1:0]  bytes_used;
    } t_result;

endpackage

[rtl/hpid_step.sv]
// ----------------------------------------------------------------------------
// hpid_step
// Combinational per-byte step: next decoder state and optional result.
// ----------------------------------------------------------------------------
module hpid_step (
    input  hpid_pkg::t_state              i_state,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_no_byte,
    input  logic                          i_hdr_partial,
    input  logic [hpid_pkg::PBITS_W-1:0]  i_prefix_bits,
    output hpid_pkg::t_state              o_state,
    output logic                          o_emit,
    output hpid_pkg::t_result             o_result
);

    logic [3:0]                   pbits;
    logic [8:0]                   mask_wide;
    logic [7:0]                   mask;
    logic [7:0]                   prefix_field;
    logic [6:0]                   group;
    logic                         more;
    logic [hpid_pkg::COUNT_W-1:0] cnt_inc;
    logic [hpid_pkg::VALUE_W-1:0] group_sh;
    logic [hpid_pkg::VALUE_W-1:0] acc_new;
    logic [hpid_pkg::VALUE_W:0]   sum;
    logic                         last_grp;

    always_comb begin
        if (i_prefix_bits == 4'd0) begin
            pbits = 4'd1;
        end else if (i_prefix_bits > 4'd8) begin
            pbits = 4'd8;
        end else begin
            pbits = i_prefix_bits;
        end
    end

    assign mask_wide    = (9'd1 << pbits) - 9'd1;
    assign mask         = mask_wide[7:0];
    assign prefix_field = i_data_byte & mask;
    assign group        = i_data_byte[6:0];
    assign more         = i_data_byte[7];
    assign cnt_inc      = i_state.count + 4'd1;
    assign group_sh     = {57'd0, group} << i_state.shift;
    // accumulator only holds groups below the current shift, so the groups never overlap
    assign acc_new      = i_state.acc | group_sh;
    assign sum          = {1'b0, acc_new} + {57'd0, mask};
    assign last_grp     = (i_state.shift == hpid_pkg::LAST_SHIFT);

    always_comb begin
        o_state                  = i_state;
        o_emit                   = 1'b0;
        o_result.value           = '0;
        o_result.status          = hpid_pkg::ST_OK;
        o_result.leading_zeros   = 1'b0;
        o_result.bytes_used      = '0;
        if (!i_state.busy) begin
            if (i_no_byte) begin
                o_emit          = 1'b1;
                o_result.status = i_hdr_partial ? hpid_pkg::ST_TRUNC : hpid_pkg::ST_EMPTY;
            end else if (prefix_field != mask) begin
                o_emit              = 1'b1;
                o_result.value      = {56'd0, prefix_field};
                o_result.bytes_used = 4'd1;
            end else begin
                o_state.busy  = 1'b1;
                o_state.acc   = '0;
                o_state.shift = '0;
                o_state.count = 4'd1;
            end
        end else if (i_no_byte) begin
            o_emit              = 1'b1;
            o_state.busy        = 1'b0;
            o_result.status     = i_hdr_partial ? hpid_pkg::ST_TRUNC : hpid_pkg::ST_MISSING;
            o_result.bytes_used = i_state.count;
        end else if (last_grp && (more || (group > 7'd1) || sum[hpid_pkg::VALUE_W])) begin
            o_emit              = 1'b1;
            o_state.busy        = 1'b0;
            o_state.count       = cnt_inc;
            o_result.status     = hpid_pkg::ST_OVERFLOW;
            o_result.bytes_used = cnt_inc;
        end else if (!more) begin
            o_emit                 = 1'b1;
            o_state.busy           = 1'b0;
            o_state.acc            = acc_new;
            o_state.count          = cnt_inc;
            o_result.value         = sum[hpid_pkg::VALUE_W-1:0];
            o_result.leading_zeros = (group == 7'd0) && (cnt_inc != 4'd2);
            o_result.bytes_used    = cnt_inc;
        end else begin
            o_state.acc   = acc_new;
            o_state.shift = i_state.shift + hpid_pkg::GROUP_BITS;
            o_state.count = cnt_inc;
        end
    end

endmodule

[rtl/hpack_integer_decoder.sv]
// ----------------------------------------------------------------------------
// hpack_integer_decoder
// HPACK prefixed integer decoder, one header byte per transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries one byte (or an end-of-buffer mark). The byte
// is captured in an input register, decoded combinationally by one pass of
// shift/OR and a single 64-bit add, and any result lands in an output
// register. Sustained rate is one byte per clock while the output is not
// stalled. The input stage advances whenever the output register is empty or
// being drained, so a new byte is taken while a finished result still waits.
// prefix_bits is written through i_cfg_we/i_cfg_data; it is to be written only
// while no integer is in progress, which the block itself does not enforce.
module hpack_integer_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hpid_pkg::PBITS_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_no_byte,
    input  logic                                i_hdr_partial,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [hpid_pkg::VALUE_W-1:0]        o_value,
    output logic [hpid_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_leading_zeros,
    output logic [hpid_pkg::COUNT_W-1:0]        o_bytes_used
);

    logic [hpid_pkg::PBITS_W-1:0] r_prefix_bits;
    logic                         r_in_valid;
    logic [7:0]                   r_data_byte;
    logic                         r_no_byte;
    logic                         r_hdr_partial;
    hpid_pkg::t_state             r_state;
    hpid_pkg::t_state             n_state;
    logic                         r_out_valid;
    hpid_pkg::t_result            r_out;
    hpid_pkg::t_result            n_out;
    logic                         emit;
    logic                         advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    hpid_step u_step (
        .i_state          (r_state),
        .i_data_byte      (r_data_byte),
        .i_no_byte        (r_no_byte),
        .i_hdr_partial    (r_hdr_partial),
        .i_prefix_bits    (r_prefix_bits),
        .o_state          (n_state),
        .o_emit           (emit),
        .o_result         (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_bits <= hpid_pkg::PREFIX_BITS_RESET;
        end else if (i_cfg_we) begin
            r_prefix_bits <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_data_byte   <= i_data_byte;
            r_no_byte     <= i_no_byte;
            r_hdr_partial <= i_hdr_partial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_value         = r_out.value;
    assign o_status        = r_out.status;
    assign o_leading_zeros = r_out.leading_zeros;
    assign o_bytes_used    = r_out.bytes_used;

    // at most ten bytes consumed while still expecting continuation bytes
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.busy |-> (r_state.count != 4'd0) && (r_state.count <= 4'd10))
        else $error("busy with bad byte count");

    // error results carry zero value and no leading-zeros flag
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != hpid_pkg::ST_OK))
            |-> (o_value == '0) && !o_leading_zeros)
        else $error("error transaction with nonzero payload");

    // leading zeros only possible past the second byte
    a_lz_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_leading_zeros) |-> (o_bytes_used > 4'd2))
        else $error("leading-zeros flag with too few bytes");

    // a result is never dropped: a stalled output keeps its valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output transaction lost");

endmodule
